@@ rtl/core/flvp_pkg.sv @@
// Shared types and constants for the FLV stream parser.
package flvp_pkg;

  typedef enum logic [1:0] {
    RK_HEADER  = 2'd0,
    RK_TAG     = 2'd1,
    RK_PAYLOAD = 2'd2,
    RK_ERROR   = 2'd3
  } result_kind_e;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_SIGNATURE = 4'd1,
    ERR_RESERVED  = 4'd2,
    ERR_OFFSET    = 4'd3,
    ERR_STREAM_ID = 4'd4,
    ERR_FRAME     = 4'd5,
    ERR_CODEC     = 4'd6,
    ERR_PKT_TYPE  = 4'd7,
    ERR_SIZE      = 4'd8
  } error_code_e;

  localparam logic [1:0] UNIT_HEADER = 2'd0;
  localparam logic [1:0] UNIT_AUDIO  = 2'd1;
  localparam logic [1:0] UNIT_VIDEO  = 2'd2;
  localparam logic [1:0] UNIT_NONE   = 2'd3;

  localparam logic [7:0]  SIG_F           = 8'h46;
  localparam logic [7:0]  SIG_L           = 8'h4C;
  localparam logic [7:0]  SIG_V           = 8'h56;
  localparam logic [7:0]  FLAGS_RSVD_MASK = 8'hFA;
  localparam logic [31:0] DATA_OFFSET     = 32'd9;

  localparam logic [3:0] FRAME_KEY   = 4'd1;
  localparam logic [3:0] FRAME_INTER = 4'd2;
  localparam logic [3:0] CODEC_H263  = 4'd2;
  localparam logic [3:0] CODEC_VP6   = 4'd4;
  localparam logic [3:0] CODEC_AVC   = 4'd7;
  localparam logic [3:0] SOUND_AAC   = 4'd10;
  localparam logic [7:0] PKT_TYPE_MAX = 8'd2;

  localparam logic [2:0] HDR_LEN_ONE  = 3'd1;
  localparam logic [2:0] HDR_LEN_TWO  = 3'd2;
  localparam logic [2:0] HDR_LEN_AVC  = 3'd5;

  typedef struct packed {
    result_kind_e result_kind;
    error_code_e  error_code;
    logic [7:0]   file_version;
    logic [1:0]   stream_flags;
    logic [23:0]  payload_length;
    logic [31:0]  time_stamp;
    logic [3:0]   codec_id;
    logic [3:0]   frame_kind;
    logic         is_config_header;
    logic [3:0]   audio_format;
    logic [7:0]   payload_byte;
    logic         last;
  } result_t;

endpackage

@@ rtl/core/flvp_if.sv @@
// Request and result channels of the FLV stream parser.
interface flvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] unit_kind;
  logic       first;

  modport source (output valid, data_byte, unit_kind, first, input ready);
  modport sink   (input valid, data_byte, unit_kind, first, output ready);
endinterface

interface flvp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  error_code;
  logic [7:0]  file_version;
  logic [1:0]  stream_flags;
  logic [23:0] payload_length;
  logic [31:0] time_stamp;
  logic [3:0]  codec_id;
  logic [3:0]  frame_kind;
  logic        is_config_header;
  logic [3:0]  audio_format;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, result_kind, error_code, file_version, stream_flags,
                  payload_length, time_stamp, codec_id, frame_kind, is_config_header,
                  audio_format, payload_byte, last, input ready);
  modport sink   (input valid, result_kind, error_code, file_version, stream_flags,
                  payload_length, time_stamp, codec_id, frame_kind, is_config_header,
                  audio_format, payload_byte, last, output ready);
endinterface

@@ rtl/core/flv_stream_parser.sv @@
// FLV stream parser top level: byte decode plus result register.
// A result is registered and appears in the cycle after the byte request that causes it.
// Throughput: one byte per cycle; input stalls only while a result waits on out_o.
// Per-byte work is one pass through the decode logic into the result register.
// Reset (rst_ni low, asynchronous) empties the result register and returns the
// parser to idle, waiting for a first-marked byte.
module flv_stream_parser
  import flvp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  flvp_in_if.sink    in_i,
  flvp_out_if.source out_o
);

  logic    fire;
  logic    res_valid;
  result_t res;
  logic    out_valid;
  result_t out_res;

  assign in_i.ready = !out_valid || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  flvp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .data_byte_i (in_i.data_byte),
    .unit_kind_i (in_i.unit_kind),
    .first_i     (in_i.first),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  flvp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && res_valid),
    .res_i   (res),
    .take_i  (out_o.ready),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign out_o.valid            = out_valid;
  assign out_o.result_kind      = out_res.result_kind;
  assign out_o.error_code       = out_res.error_code;
  assign out_o.file_version     = out_res.file_version;
  assign out_o.stream_flags     = out_res.stream_flags;
  assign out_o.payload_length   = out_res.payload_length;
  assign out_o.time_stamp       = out_res.time_stamp;
  assign out_o.codec_id         = out_res.codec_id;
  assign out_o.frame_kind       = out_res.frame_kind;
  assign out_o.is_config_header = out_res.is_config_header;
  assign out_o.audio_format     = out_res.audio_format;
  assign out_o.payload_byte     = out_res.payload_byte;
  assign out_o.last             = out_res.last;

endmodule

@@ rtl/core/flvp_core.sv @@
// Byte parser state and per-byte decode logic.
module flvp_core
  import flvp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] data_byte_i,
  input  logic [1:0] unit_kind_i,
  input  logic       first_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_SIG, PH_VER, PH_FLAGS, PH_OFF,
    PH_SIZE, PH_STAMP, PH_EXT, PH_SID,
    PH_VTC, PH_VADJ, PH_VPKT, PH_VCT,
    PH_AFMT, PH_AAAC, PH_PAY
  } phase_e;

  phase_e      phase_q, phase_d, phase_s;
  logic [2:0]  fi_q, fi_d, fi_s;
  logic [23:0] bl_q, bl_d, bl_s;
  logic [23:0] tag_q, tag_d, tag_s;
  logic [31:0] stamp_q, stamp_d, stamp_s;
  logic [31:0] off_q, off_d, off_s;
  logic [3:0]  codec_q, codec_d, codec_s;
  logic [3:0]  frame_q, frame_d, frame_s;
  logic        hdr_q, hdr_d, hdr_s;
  logic [3:0]  audio_q, audio_d, audio_s;
  logic [7:0]  ver_q, ver_d, ver_s;
  logic [1:0]  flags_q, flags_d, flags_s;
  logic [1:0]  unit_q, unit_d, unit_s;

  logic        err_req, info_req, head_req, pay_req;
  error_code_e err_code;
  logic [2:0]  consumed;
  logic [2:0]  need;
  logic [7:0]  want;

  // A first byte restarts from the cleared state.
  always_comb begin
    if (first_i) begin
      fi_s    = '0;
      bl_s    = '0;
      tag_s   = '0;
      stamp_s = '0;
      off_s   = '0;
      codec_s = '0;
      frame_s = '0;
      hdr_s   = 1'b0;
      audio_s = '0;
      ver_s   = '0;
      flags_s = '0;
      unit_s  = unit_kind_i;
      if (unit_kind_i == UNIT_HEADER) begin
        phase_s = PH_SIG;
      end else if (unit_kind_i == UNIT_NONE) begin
        phase_s = PH_IDLE;
      end else begin
        phase_s = PH_SIZE;
      end
    end else begin
      phase_s = phase_q;
      fi_s    = fi_q;
      bl_s    = bl_q;
      tag_s   = tag_q;
      stamp_s = stamp_q;
      off_s   = off_q;
      codec_s = codec_q;
      frame_s = frame_q;
      hdr_s   = hdr_q;
      audio_s = audio_q;
      ver_s   = ver_q;
      flags_s = flags_q;
      unit_s  = unit_q;
    end
  end

  always_comb begin
    phase_d  = phase_s;
    fi_d     = fi_s;
    bl_d     = bl_s;
    tag_d    = tag_s;
    stamp_d  = stamp_s;
    off_d    = off_s;
    codec_d  = codec_s;
    frame_d  = frame_s;
    hdr_d    = hdr_s;
    audio_d  = audio_s;
    ver_d    = ver_s;
    flags_d  = flags_s;
    unit_d   = unit_s;
    err_req  = 1'b0;
    info_req = 1'b0;
    head_req = 1'b0;
    pay_req  = 1'b0;
    err_code = ERR_NONE;
    consumed = HDR_LEN_ONE;
    need     = HDR_LEN_ONE;
    want     = SIG_V;
    res_o    = '0;

    unique case (phase_s)
      PH_IDLE: ;
      PH_SIG: begin
        if (fi_s == 3'd0) begin
          want = SIG_F;
        end else if (fi_s == 3'd1) begin
          want = SIG_L;
        end
        if (data_byte_i != want) begin
          err_req  = 1'b1;
          err_code = ERR_SIGNATURE;
        end else if (fi_s == 3'd2) begin
          fi_d    = '0;
          phase_d = PH_VER;
        end else begin
          fi_d = 3'(fi_s + 3'd1);
        end
      end
      PH_VER: begin
        ver_d   = data_byte_i;
        phase_d = PH_FLAGS;
      end
      PH_FLAGS: begin
        if ((data_byte_i & FLAGS_RSVD_MASK) != 8'd0) begin
          err_req  = 1'b1;
          err_code = ERR_RESERVED;
        end else begin
          flags_d = {data_byte_i[2], data_byte_i[0]};
          off_d   = '0;
          fi_d    = '0;
          phase_d = PH_OFF;
        end
      end
      PH_OFF: begin
        off_d = {off_s[23:0], data_byte_i};
        fi_d  = 3'(fi_s + 3'd1);
        if (fi_s == 3'd3) begin
          if (off_d != DATA_OFFSET) begin
            err_req  = 1'b1;
            err_code = ERR_OFFSET;
          end else begin
            head_req = 1'b1;
            phase_d  = PH_IDLE;
          end
        end
      end
      PH_SIZE: begin
        tag_d = {tag_s[15:0], data_byte_i};
        if (fi_s == 3'd2) begin
          fi_d    = '0;
          phase_d = PH_STAMP;
        end else begin
          fi_d = 3'(fi_s + 3'd1);
        end
      end
      PH_STAMP: begin
        stamp_d = {8'd0, stamp_s[15:0], data_byte_i};
        if (fi_s == 3'd2) begin
          fi_d    = '0;
          phase_d = PH_EXT;
        end else begin
          fi_d = 3'(fi_s + 3'd1);
        end
      end
      PH_EXT: begin
        stamp_d = {data_byte_i, stamp_s[23:0]};
        off_d   = '0;
        phase_d = PH_SID;
      end
      PH_SID: begin
        off_d = off_s | {24'd0, data_byte_i};
        if (fi_s == 3'd2) begin
          fi_d = '0;
          if (off_d != 32'd0) begin
            err_req  = 1'b1;
            err_code = ERR_STREAM_ID;
          end else if (tag_s == 24'd0) begin
            err_req  = 1'b1;
            err_code = ERR_SIZE;
          end else begin
            phase_d = (unit_s == UNIT_VIDEO) ? PH_VTC : PH_AFMT;
          end
        end else begin
          fi_d = 3'(fi_s + 3'd1);
        end
      end
      PH_VTC: begin
        frame_d = data_byte_i[7:4];
        codec_d = data_byte_i[3:0];
        if (codec_d == CODEC_VP6) begin
          need = HDR_LEN_TWO;
        end else if (codec_d == CODEC_AVC) begin
          need = HDR_LEN_AVC;
        end
        if (frame_d != FRAME_KEY && frame_d != FRAME_INTER) begin
          err_req  = 1'b1;
          err_code = ERR_FRAME;
        end else if (codec_d != CODEC_H263 && codec_d != CODEC_VP6 &&
                     codec_d != CODEC_AVC) begin
          err_req  = 1'b1;
          err_code = ERR_CODEC;
        end else if (tag_s < {21'd0, need}) begin
          err_req  = 1'b1;
          err_code = ERR_SIZE;
        end else if (codec_d == CODEC_H263) begin
          info_req = 1'b1;
          consumed = HDR_LEN_ONE;
        end else begin
          phase_d = (codec_d == CODEC_VP6) ? PH_VADJ : PH_VPKT;
        end
      end
      PH_VADJ: begin
        info_req = 1'b1;
        consumed = HDR_LEN_TWO;
      end
      PH_VPKT: begin
        if (data_byte_i > PKT_TYPE_MAX) begin
          err_req  = 1'b1;
          err_code = ERR_PKT_TYPE;
        end else begin
          hdr_d   = (data_byte_i == 8'd0);
          fi_d    = '0;
          phase_d = PH_VCT;
        end
      end
      PH_VCT: begin
        if (fi_s == 3'd2) begin
          fi_d     = '0;
          info_req = 1'b1;
          consumed = HDR_LEN_AVC;
        end else begin
          fi_d = 3'(fi_s + 3'd1);
        end
      end
      PH_AFMT: begin
        codec_d = data_byte_i[7:4];
        audio_d = data_byte_i[3:0];
        if (codec_d == SOUND_AAC) begin
          if (tag_s < 24'd2) begin
            err_req  = 1'b1;
            err_code = ERR_SIZE;
          end else begin
            phase_d = PH_AAAC;
          end
        end else begin
          info_req = 1'b1;
          consumed = HDR_LEN_ONE;
        end
      end
      PH_AAAC: begin
        hdr_d    = (data_byte_i == 8'd0);
        info_req = 1'b1;
        consumed = HDR_LEN_TWO;
      end
      PH_PAY: begin
        bl_d    = 24'(bl_s - 24'd1);
        pay_req = 1'b1;
        if (bl_d == 24'd0) begin
          phase_d = PH_IDLE;
        end
      end
    endcase

    if (err_req) begin
      phase_d           = PH_IDLE;
      res_o.result_kind = RK_ERROR;
      res_o.error_code  = err_code;
      res_o.last        = 1'b1;
    end else if (head_req) begin
      res_o.result_kind  = RK_HEADER;
      res_o.file_version = ver_s;
      res_o.stream_flags = flags_s;
      res_o.last         = 1'b1;
    end else if (info_req) begin
      bl_d                   = 24'(tag_s - {21'd0, consumed});
      phase_d                = (bl_d == 24'd0) ? PH_IDLE : PH_PAY;
      res_o.result_kind      = RK_TAG;
      res_o.payload_length   = bl_d;
      res_o.time_stamp       = stamp_d;
      res_o.codec_id         = codec_d;
      res_o.frame_kind       = (unit_s == UNIT_VIDEO) ? frame_d : 4'd0;
      res_o.is_config_header = hdr_d;
      res_o.audio_format     = (unit_s == UNIT_AUDIO) ? audio_d : 4'd0;
      res_o.last             = (bl_d == 24'd0);
    end else if (pay_req) begin
      res_o.result_kind  = RK_PAYLOAD;
      res_o.payload_byte = data_byte_i;
      res_o.last         = (bl_d == 24'd0);
    end
  end

  assign res_valid_o = err_req | head_req | info_req | pay_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fi_q    <= '0;
      bl_q    <= '0;
      tag_q   <= '0;
      stamp_q <= '0;
      off_q   <= '0;
      codec_q <= '0;
      frame_q <= '0;
      hdr_q   <= 1'b0;
      audio_q <= '0;
      ver_q   <= '0;
      flags_q <= '0;
      unit_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      fi_q    <= fi_d;
      bl_q    <= bl_d;
      tag_q   <= tag_d;
      stamp_q <= stamp_d;
      off_q   <= off_d;
      codec_q <= codec_d;
      frame_q <= frame_d;
      hdr_q   <= hdr_d;
      audio_q <= audio_d;
      ver_q   <= ver_d;
      flags_q <= flags_d;
      unit_q  <= unit_d;
    end
  end

endmodule

@@ rtl/core/flvp_out_stage.sv @@
// Result register between the decode logic and the output channel.
module flvp_out_stage
  import flvp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    take_i,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ rtl/core/flvp_checker.sv @@
// Port-level assertions for the FLV stream parser, bound to the top level.
module flvp_checker
  import flvp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_i,
  input logic [3:0]  error_code_i,
  input logic [23:0] payload_length_i,
  input logic        last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i == RK_ERROR |-> last_i && error_code_i != ERR_NONE)
    else $error("error result without last or code");

  a_code_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i != RK_ERROR |-> error_code_i == ERR_NONE)
    else $error("error code on non-error result");

  a_tag_last_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i == RK_TAG |-> last_i == (payload_length_i == 24'd0))
    else $error("tag info last mismatch");

endmodule

bind flv_stream_parser flvp_checker u_flvp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .result_kind_i    (out_o.result_kind),
  .error_code_i     (out_o.error_code),
  .payload_length_i (out_o.payload_length),
  .last_i           (out_o.last)
);
